[rtl/itoa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_pkg
// Types, codes and character helpers shared by the integer-to-ascii block.
// ----------------------------------------------------------------------------
package itoa_pkg;

   localparam int unsigned NUMBER_W = 32;
   localparam int unsigned CHAR_W   = 8;

   // conversion selector codes
   localparam logic [1:0] OP_SIGNED_DEC   = 2'd0;
   localparam logic [1:0] OP_UNSIGNED_DEC = 2'd1;
   localparam logic [1:0] OP_HEX          = 2'd2;
   localparam logic [1:0] OP_HEX_ALT      = 2'd3;

   localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_MINUS  = 8'h2d;

   typedef struct packed {
      logic [1:0]          op;
      logic [NUMBER_W-1:0] number;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] ascii_char;
      logic              last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SKIP,
      ST_SIGN,
      ST_EMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic step;
      logic dec_ptr;
      logic emit_sign;
      logic emit_digit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic hex;
      logic neg;
      logic conv_done;
      logic digit_zero;
      logic ptr_zero;
      logic out_free;
   } sts_type;

   function automatic logic [CHAR_W-1:0] digit_to_char(input logic [3:0] d);
      logic [CHAR_W-1:0] c;
      if (d < 4'd10) begin
         c = CHAR_ZERO + {4'd0, d};
      end else begin
         c = CHAR_LOWER_A + {4'd0, d - 4'd10};
      end
      return c;
   endfunction

endpackage

[rtl/integer_to_ascii_digits_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_digits_core
// Prints one word as signed decimal, unsigned decimal or lowercase hex ASCII,
// most significant digit first, no leading zeros, last flag on final char.
// ----------------------------------------------------------------------------
//  channel  ports                          payload   direction
//  request  req_valid req_ready req_data   req_type  in
//  response rsp_valid rsp_ready rsp_data   rsp_type  out
//
// Decimal: accept, a shift-add-3 step for every value bit, a skip step per
// leading zero digit, a dispatch step, then one character per cycle while the
// response side takes them, the sign first when negative.
// Hex: accept, dispatch, then the same skip and emission.
// Synchronous active-high reset returns the sequencer to idle, output empty.
// A stalled response holds the emitter; a new request is
// taken once the last character of the previous one sits in the output register.
// ----------------------------------------------------------------------------
module integer_to_ascii_digits_core #(
   parameter int unsigned VALUE_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  itoa_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output itoa_pkg::rsp_type rsp_data
);
   import itoa_pkg::*;

   cmd_type cmd;
   sts_type sts;

   itoa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   itoa_dp #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // one transaction in flight inside the converter
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a conversion was running");

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.step, cmd.emit_sign, cmd.emit_digit}))
      else $error("conflicting datapath commands");

   // never overwrite a character still waiting in the output register
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_sign || cmd.emit_digit) |-> (!rsp_valid || rsp_ready))
      else $error("output register overwritten");

endmodule

[rtl/itoa_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_ctrl
// Sequencer: load, binary-to-bcd conversion, leading zero skip, emission.
// ----------------------------------------------------------------------------
module itoa_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  itoa_pkg::sts_type sts,
   output itoa_pkg::cmd_type cmd
);
   import itoa_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            // hex digits are already in place after load
            if (sts.hex) begin
               state_in = ST_SKIP;
            end else begin
               cmd.step = 1'b1;
               if (sts.conv_done) begin
                  state_in = ST_SKIP;
               end
            end
         end
         ST_SKIP: begin
            if (sts.digit_zero && !sts.ptr_zero) begin
               cmd.dec_ptr = 1'b1;
            end else if (sts.neg) begin
               state_in = ST_SIGN;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_SIGN: begin
            if (sts.out_free) begin
               cmd.emit_sign = 1'b1;
               state_in      = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit_digit = 1'b1;
               if (sts.ptr_zero) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/itoa_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_dp
// Datapath: magnitude, shift-add-3 bcd converter, digit pointer, output stage.
// ----------------------------------------------------------------------------
module itoa_dp #(
   parameter int unsigned VALUE_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  itoa_pkg::req_type req_data,
   input  itoa_pkg::cmd_type cmd,
   output itoa_pkg::sts_type sts,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output itoa_pkg::rsp_type rsp_data
);
   import itoa_pkg::*;

   // decimal digits needed for 2^VALUE_WIDTH - 1 (also covers hex digits)
   localparam int unsigned NUM_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
   localparam int unsigned BCD_W      = NUM_DIGITS * 4;
   localparam int unsigned PTR_W      = $clog2(NUM_DIGITS);
   localparam int unsigned CNT_W      = $clog2(VALUE_WIDTH);

   logic [VALUE_WIDTH-1:0] value;
   logic [VALUE_WIDTH-1:0] mag;
   logic                   is_hex;
   logic                   is_neg;

   logic                   neg_ff, neg_in;
   logic                   hex_ff, hex_in;
   logic [VALUE_WIDTH-1:0] sh_ff, sh_in;
   logic [BCD_W-1:0]       bcd_ff, bcd_in;
   logic [BCD_W-1:0]       bcd_adj;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [PTR_W-1:0]       ptr_ff, ptr_in;
   rsp_type                rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [3:0]             cur_digit;
   logic                   out_free;

   assign value  = VALUE_WIDTH'(req_data.number);
   assign is_hex = (req_data.op == OP_HEX) || (req_data.op == OP_HEX_ALT);
   assign is_neg = (req_data.op == OP_SIGNED_DEC) && value[VALUE_WIDTH-1];
   assign mag    = is_neg ? (~value + 1'b1) : value;

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[i*4 +: 4] >= 4'd5) begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4] + 4'd3;
         end else begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4];
         end
      end
   end

   assign cur_digit = bcd_ff[ptr_ff*4 +: 4];
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      neg_in = neg_ff;
      hex_in = hex_ff;
      sh_in  = sh_ff;
      bcd_in = bcd_ff;
      cnt_in = cnt_ff;
      ptr_in = ptr_ff;
      rsp_in = rsp_ff;
      if (cmd.load) begin
         neg_in = is_neg;
         hex_in = is_hex;
         sh_in  = mag;
         bcd_in = is_hex ? BCD_W'(mag) : '0;
         cnt_in = '0;
         ptr_in = PTR_W'(NUM_DIGITS - 1);
      end
      if (cmd.step) begin
         bcd_in = {bcd_adj[BCD_W-2:0], sh_ff[VALUE_WIDTH-1]};
         sh_in  = {sh_ff[VALUE_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
      end
      if (cmd.dec_ptr || (cmd.emit_digit && ptr_ff != '0)) begin
         ptr_in = ptr_ff - 1'b1;
      end
      if (cmd.emit_sign) begin
         rsp_in.ascii_char = CHAR_MINUS;
         rsp_in.last       = 1'b0;
      end
      if (cmd.emit_digit) begin
         rsp_in.ascii_char = digit_to_char(cur_digit);
         rsp_in.last       = (ptr_ff == '0);
      end
   end

   always_comb begin
      if (cmd.emit_sign || cmd.emit_digit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      hex_ff <= hex_in;
      sh_ff  <= sh_in;
      bcd_ff <= bcd_in;
      cnt_ff <= cnt_in;
      ptr_ff <= ptr_in;
      rsp_ff <= rsp_in;
   end

   assign sts.hex        = hex_ff;
   assign sts.neg        = neg_ff;
   assign sts.conv_done  = (cnt_ff == CNT_W'(VALUE_WIDTH - 1));
   assign sts.digit_zero = (cur_digit == 4'd0);
   assign sts.ptr_zero   = (ptr_ff == '0);
   assign sts.out_free   = out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[dv/integer_to_ascii_digits_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_digits_core_test
// Self-checking bench for the word-to-ascii printer. Words go in as signed
// decimal, unsigned decimal and hex requests; every character that comes back
// is checked against a local digit predictor, with random gaps and stalls.
// ----------------------------------------------------------------------------
module integer_to_ascii_digits_core_test;
   import itoa_pkg::*;

   localparam int unsigned CLOCK_PERIOD   = 8;
   localparam int unsigned RESET_CYCLES   = 9;
   localparam int unsigned RANDOM_WORDS   = 107;
   localparam int unsigned WATCHDOG_LIMIT = 4000;
   localparam int unsigned TAIL_CYCLES    = 64;
   localparam int          SIDE_REQ       = 0;
   localparam int          SIDE_RSP       = 1;

   typedef struct {
      req_type word;
      bit      drain;
   } pending_word_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   pending_word_type pending_words[$];
   rsp_type          expected_chars[$];

   logic        req_taken = 1'b0;
   int unsigned gap_left = 0;
   int unsigned stall_left = 0;
   int unsigned idle_burst[2] = '{0, 0};
   int unsigned idle_cycles = 0;
   int unsigned error_count = 0;
   int unsigned words_sent = 0;
   int unsigned chars_seen = 0;
   int unsigned op_count[4] = '{0, 0, 0, 0};

   integer_to_ascii_digits_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // most gaps short, a few long, and now and then a run with none at all
   function automatic int unsigned idle_len(input int side);
      int unsigned r;
      if (idle_burst[side] > 0) begin
         idle_burst[side]--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
         idle_burst[side] = $urandom_range(8, 30);
         return 0;
      end
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 70);
   endfunction

   // characters of one word, most significant digit first
   function automatic void predict_chars(input req_type word);
      string             glyphs;
      logic [31:0]       mag;
      logic              neg;
      logic [31:0]       base;
      logic [CHAR_W-1:0] rev[$];
      rsp_type           c;
      glyphs = "0123456789abcdef";
      neg = (word.op == OP_SIGNED_DEC) && word.number[NUMBER_W-1];
      mag = neg ? (32'd0 - word.number) : word.number;
      // the spare selector code prints hex as well
      base = (word.op == OP_HEX || word.op == OP_HEX_ALT) ? 32'd16 : 32'd10;
      do begin
         rev.push_front(glyphs[mag % base]);
         mag = mag / base;
      end while (mag != 0);
      if (neg) begin
         c.ascii_char = CHAR_MINUS;
         c.last       = 1'b0;
         expected_chars.push_back(c);
      end
      foreach (rev[i]) begin
         c.ascii_char = rev[i];
         c.last       = (i == rev.size() - 1);
         expected_chars.push_back(c);
      end
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH %s", $realtime, msg);
      error_count++;
   endtask

   function automatic void queue_word(input logic [1:0] op, input logic [31:0] number,
                                      input bit drain);
      pending_word_type p;
      p.word.op     = op;
      p.word.number = number;
      p.drain       = drain;
      pending_words.push_back(p);
   endfunction

   function automatic logic [1:0] random_op();
      case ($urandom_range(0, 9))
         0:       return OP_HEX_ALT;
         1, 2, 3: return OP_SIGNED_DEC;
         4, 5, 6: return OP_UNSIGNED_DEC;
         default: return OP_HEX;
      endcase
   endfunction

   function automatic logic [31:0] random_number();
      logic [31:0] p;
      int unsigned k;
      p = 32'd1;
      k = $urandom_range(0, 9);
      repeat (k) p = p * 32'd10;
      case ($urandom_range(0, 6))
         0:       return $urandom;
         1:       return $urandom_range(0, 120);
         // either side of a power of ten
         2:       return p + $urandom_range(0, 2) - 32'd1;
         3:       return (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
         4:       return 32'd0 - $urandom_range(1, 1000);
         5:       return 32'd0 - p - $urandom_range(0, 1);
         default: return $urandom >> $urandom_range(0, 31);
      endcase
   endfunction

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_words.size() > 0 &&
                      !(pending_words[0].drain && expected_chars.size() != 0)) begin
            req_data  <= pending_words[0].word;
            req_valid <= 1'b1;
            void'(pending_words.pop_front());
            words_sent++;
            gap_left = idle_len(SIDE_REQ);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
         stall_left = idle_len(SIDE_RSP);
      end
   end

   // monitor, checker and watchdog
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            predict_chars(req_data);
            op_count[req_data.op]++;
         end
         if (rsp_valid && rsp_ready) begin
            chars_seen++;
            if (expected_chars.size() == 0) begin
               report_mismatch($sformatf("char %0d: unexpected transaction %02h last %0b",
                                         chars_seen, rsp_data.ascii_char, rsp_data.last));
            end else begin
               want = expected_chars.pop_front();
               if (rsp_data.ascii_char !== want.ascii_char)
                  report_mismatch($sformatf("char %0d: ascii_char got %02h want %02h",
                                            chars_seen, rsp_data.ascii_char,
                                            want.ascii_char));
               if (rsp_data.last !== want.last)
                  report_mismatch($sformatf("char %0d: last got %0b want %0b",
                                            chars_seen, rsp_data.last, want.last));
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
               $display("watchdog: no transaction for %0d cycles, %0d chars outstanding",
                        idle_cycles, expected_chars.size());
               $display("Simulation FAILED");
               $finish;
            end
         end
      end
   end

   initial begin
      // directed: extremes, every selector, zero, most negative value
      queue_word(OP_SIGNED_DEC,   32'h0000_0000, 1'b0);
      queue_word(OP_SIGNED_DEC,   32'h0000_0001, 1'b0);
      queue_word(OP_SIGNED_DEC,   32'hffff_ffff, 1'b0);
      queue_word(OP_SIGNED_DEC,   32'h7fff_ffff, 1'b0);
      queue_word(OP_SIGNED_DEC,   32'h8000_0000, 1'b0);
      queue_word(OP_SIGNED_DEC,   32'd10,        1'b0);
      queue_word(OP_SIGNED_DEC,   32'hffff_fff6, 1'b0);
      queue_word(OP_UNSIGNED_DEC, 32'h0000_0000, 1'b0);
      queue_word(OP_UNSIGNED_DEC, 32'hffff_ffff, 1'b0);
      queue_word(OP_UNSIGNED_DEC, 32'h8000_0000, 1'b0);
      queue_word(OP_UNSIGNED_DEC, 32'd9,         1'b0);
      queue_word(OP_UNSIGNED_DEC, 32'd999999999, 1'b0);
      queue_word(OP_UNSIGNED_DEC, 32'd1000000000, 1'b0);
      queue_word(OP_UNSIGNED_DEC, 32'd1,         1'b0);
      queue_word(OP_HEX,          32'h0000_0000, 1'b0);
      queue_word(OP_HEX,          32'hffff_ffff, 1'b0);
      queue_word(OP_HEX,          32'h0000_000f, 1'b0);
      queue_word(OP_HEX,          32'h0000_0010, 1'b0);
      queue_word(OP_HEX,          32'h8000_0000, 1'b0);
      queue_word(OP_HEX,          32'hdead_beef, 1'b0);
      queue_word(OP_HEX_ALT,      32'h0000_0000, 1'b0);
      queue_word(OP_HEX_ALT,      32'h00ab_cdef, 1'b0);
      queue_word(OP_HEX_ALT,      32'hffff_ffff, 1'b0);
      // random words; two of them wait for the response side to drain first
      for (int i = 0; i < RANDOM_WORDS; i++)
         queue_word(random_op(), random_number(), (i == 0) || (i == RANDOM_WORDS / 2));

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_words.size() > 0 || req_valid || expected_chars.size() > 0)
         @(posedge clock);
      // anything arriving now is an extra character
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("checked %0d words: %0d signed dec, %0d unsigned dec, %0d hex, %0d spare op",
               words_sent, op_count[OP_SIGNED_DEC], op_count[OP_UNSIGNED_DEC],
               op_count[OP_HEX], op_count[OP_HEX_ALT]);
      $display("%0d characters compared, %0d mismatches", chars_seen, error_count);
      if (error_count == 0 && expected_chars.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
